/* rtl/segregated_free_list_allocator_assert.svh */
// Assertion macros used by the allocator RTL.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SFLA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SFLA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/sfla_pkg.sv */
// Types, constants and helpers for the segregated free-list allocator.
`default_nettype none

package sfla_pkg;

   localparam int LEN_W        = 12;
   localparam int ADDR_W       = 16;
   localparam int STORED_LEN_W = 10;
   localparam int CLASS_W      = 6;
   localparam int MAX_CLASSES  = 64;
   localparam int SLOT_W       = 14;
   localparam int STORE_DEPTH  = 16384;
   localparam int BUMP_W       = 17;
   localparam int ARENA_BYTES  = 65536;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 16;

   localparam logic [BUMP_W-1:0] BUMP_RESET = 17'd516;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LONG  = 2'd1,
      STATUS_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_POP,
      ST_PUSH
   } state_type;

   // One read and one write port of a per-block store.
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
   } store_cmd_type;

   // Stores are indexed by the word address of the block header.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] addr);
      return addr[ADDR_W-1:2];
   endfunction

   // 16 * (class + 1) content bytes plus the 4-byte header.
   function automatic logic [10:0] block_bytes(input logic [CLASS_W-1:0] cls);
      logic [CLASS_W:0] units;
      units = {1'b0, cls} + 7'd1;
      return {units, 4'b0100};
   endfunction

endpackage

`default_nettype wire

/* rtl/sfla_ram.sv */
// Single-port-write, single-port-read synchronous store, one entry per header word.
`default_nettype none

module sfla_ram #(
   parameter int WIDTH = sfla_pkg::STORED_LEN_W
) (
   input  wire logic                  clock,
   input  wire sfla_pkg::store_cmd_type cmd,
   input  wire logic [WIDTH-1:0]      wr_data,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [sfla_pkg::STORE_DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_slot] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_slot];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/sfla_heads.sv */
// Free-list head table: synchronous memory with per-entry valid bits (invalid reads as 0).
`default_nettype none

module sfla_heads #(
   parameter int NUM_CLASSES = sfla_pkg::MAX_CLASSES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(NUM_CLASSES)-1:0]    rd_idx,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(NUM_CLASSES)-1:0]    wr_idx,
   input  wire logic [sfla_pkg::ADDR_W-1:0]       wr_data,
   output logic      [sfla_pkg::ADDR_W-1:0]       rd_data
);

   logic [sfla_pkg::ADDR_W-1:0] mem [NUM_CLASSES];
   logic [NUM_CLASSES-1:0]      valid_ff;
   logic [sfla_pkg::ADDR_W-1:0] rd_data_ff;
   logic                        rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   // never-written head means empty list
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* rtl/sfla_ctrl.sv */
// Request sequencer: head/length lookups, pop, push, bump pointer and result register.
`default_nettype none
`include "segregated_free_list_allocator_assert.svh"

module sfla_ctrl #(
   parameter int NUM_CLASSES = sfla_pkg::MAX_CLASSES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [sfla_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [sfla_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic      [1:0]                           rsp_tuser,
   output logic                                      heads_rd_en,
   output logic      [$clog2(NUM_CLASSES)-1:0]       heads_rd_idx,
   output logic                                      heads_wr_en,
   output logic      [$clog2(NUM_CLASSES)-1:0]       heads_wr_idx,
   output logic      [sfla_pkg::ADDR_W-1:0]          heads_wr_data,
   input  wire logic [sfla_pkg::ADDR_W-1:0]          heads_rd_data,
   output sfla_pkg::store_cmd_type                   len_cmd,
   output logic      [sfla_pkg::STORED_LEN_W-1:0]    len_wr_data,
   input  wire logic [sfla_pkg::STORED_LEN_W-1:0]    len_rd_data,
   output sfla_pkg::store_cmd_type                   link_cmd,
   output logic      [sfla_pkg::ADDR_W-1:0]          link_wr_data,
   input  wire logic [sfla_pkg::ADDR_W-1:0]          link_rd_data
);

   localparam int IDX_W = $clog2(NUM_CLASSES);

   sfla_pkg::state_type state_ff, state_in;

   sfla_pkg::op_type                op_ff;
   logic [sfla_pkg::LEN_W-1:0]      len_ff;
   logic [sfla_pkg::ADDR_W-1:0]     addr_ff;
   logic [sfla_pkg::CLASS_W-1:0]    class_ff;
   logic                            too_long_ff;
   logic [sfla_pkg::ADDR_W-1:0]     head_ff;
   logic [sfla_pkg::BUMP_W-1:0]     bump_ff;

   logic                            rsp_valid_ff;
   logic [sfla_pkg::ADDR_W-1:0]     rsp_addr_ff;
   sfla_pkg::status_type            rsp_status_ff;

   // request decode
   sfla_pkg::op_type                in_op;
   logic [sfla_pkg::LEN_W-1:0]      in_len;
   logic [sfla_pkg::ADDR_W-1:0]     in_addr;
   logic [sfla_pkg::CLASS_W-1:0]    in_class;
   logic                            in_too_long;
   logic                            req_fire;
   logic                            out_free;

   // lookup results
   logic [sfla_pkg::CLASS_W-1:0]    stored_class;
   logic                            free_in_range;
   logic [10:0]                     blk;
   logic [sfla_pkg::BUMP_W:0]       bump_next;
   logic [sfla_pkg::BUMP_W:0]       bump_probe;
   logic                            exhausted;

   // sequencer outputs
   logic                            fin;
   logic                            bump_we;
   logic [sfla_pkg::ADDR_W-1:0]     fin_addr;
   sfla_pkg::status_type            fin_status;

   assign in_op       = sfla_pkg::op_type'(req_tuser);
   assign in_len      = req_tdata[11:0];
   assign in_addr     = req_tdata[27:12];
   assign in_class    = in_len[9:4];
   assign in_too_long = (in_len[11:10] != 2'b00) ||
                        ({1'b0, in_class} >= (sfla_pkg::CLASS_W+1)'(NUM_CLASSES));

   assign req_tready = (state_ff == sfla_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign stored_class  = len_rd_data[9:4];
   assign free_in_range = {1'b0, stored_class} < (sfla_pkg::CLASS_W+1)'(NUM_CLASSES);

   // bump fails when pointer + 2 * block reaches the arena end
   assign blk        = sfla_pkg::block_bytes(class_ff);
   assign bump_next  = {1'b0, bump_ff} + (sfla_pkg::BUMP_W+1)'(blk);
   assign bump_probe = {1'b0, bump_ff} + (sfla_pkg::BUMP_W+1)'({blk, 1'b0});
   assign exhausted  = bump_probe >= (sfla_pkg::BUMP_W+1)'(sfla_pkg::ARENA_BYTES);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfla_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sfla_pkg::ST_LOOKUP;
            end
         end
         sfla_pkg::ST_LOOKUP: begin
            if (op_ff == sfla_pkg::OP_ALLOC) begin
               if (!too_long_ff && (heads_rd_data != '0)) begin
                  state_in = sfla_pkg::ST_POP;
               end else if (out_free) begin
                  state_in = sfla_pkg::ST_IDLE;
               end
            end else begin
               if (free_in_range) begin
                  state_in = sfla_pkg::ST_PUSH;
               end else if (out_free) begin
                  state_in = sfla_pkg::ST_IDLE;
               end
            end
         end
         sfla_pkg::ST_POP, sfla_pkg::ST_PUSH: begin
            if (out_free) begin
               state_in = sfla_pkg::ST_IDLE;
            end
         end
         default: state_in = sfla_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      heads_rd_en   = 1'b0;
      heads_rd_idx  = in_class[IDX_W-1:0];
      heads_wr_en   = 1'b0;
      heads_wr_idx  = class_ff[IDX_W-1:0];
      heads_wr_data = addr_ff;
      len_cmd       = '0;
      len_wr_data   = len_ff[sfla_pkg::STORED_LEN_W-1:0];
      link_cmd      = '0;
      link_wr_data  = heads_rd_data;
      fin           = 1'b0;
      bump_we       = 1'b0;
      fin_addr      = '0;
      fin_status    = sfla_pkg::STATUS_OK;
      unique case (state_ff)
         sfla_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (in_op == sfla_pkg::OP_ALLOC) begin
                  heads_rd_en = 1'b1;
               end else begin
                  len_cmd.rd_en   = 1'b1;
                  len_cmd.rd_slot = sfla_pkg::slot_of(in_addr);
               end
            end
         end
         sfla_pkg::ST_LOOKUP: begin
            if (op_ff == sfla_pkg::OP_ALLOC) begin
               if (too_long_ff) begin
                  fin        = out_free;
                  fin_status = sfla_pkg::STATUS_TOO_LONG;
               end else if (heads_rd_data != '0) begin
                  link_cmd.rd_en   = 1'b1;
                  link_cmd.rd_slot = sfla_pkg::slot_of(heads_rd_data);
               end else if (exhausted) begin
                  fin        = out_free;
                  fin_status = sfla_pkg::STATUS_EXHAUSTED;
               end else begin
                  fin             = out_free;
                  bump_we         = out_free;
                  fin_addr        = bump_ff[sfla_pkg::ADDR_W-1:0];
                  len_cmd.wr_en   = out_free;
                  len_cmd.wr_slot = sfla_pkg::slot_of(bump_ff[sfla_pkg::ADDR_W-1:0]);
               end
            end else begin
               if (free_in_range) begin
                  heads_rd_en  = 1'b1;
                  heads_rd_idx = stored_class[IDX_W-1:0];
               end else begin
                  fin = out_free;
               end
            end
         end
         sfla_pkg::ST_POP: begin
            fin             = out_free;
            fin_addr        = head_ff;
            heads_wr_en     = out_free;
            heads_wr_data   = link_rd_data;
            len_cmd.wr_en   = out_free;
            len_cmd.wr_slot = sfla_pkg::slot_of(head_ff);
         end
         sfla_pkg::ST_PUSH: begin
            fin              = out_free;
            heads_wr_en      = out_free;
            link_cmd.wr_en   = out_free;
            link_cmd.wr_slot = sfla_pkg::slot_of(addr_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfla_pkg::ST_IDLE;
         bump_ff      <= sfla_pkg::BUMP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (bump_we) begin
            bump_ff <= bump_next[sfla_pkg::BUMP_W-1:0];
         end
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= in_op;
         len_ff      <= in_len;
         addr_ff     <= in_addr;
         class_ff    <= in_class;
         too_long_ff <= in_too_long;
      end
      if (state_ff == sfla_pkg::ST_LOOKUP) begin
         head_ff <= heads_rd_data;
         if (op_ff == sfla_pkg::OP_FREE) begin
            class_ff <= stored_class;
         end
      end
      if (fin) begin
         rsp_addr_ff   <= fin_addr;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   `SFLA_ASSERT(a_single_request, req_fire |=> !req_tready, "request accepted while another in flight")
   `SFLA_ASSERT(a_pop_nonzero, (fin && (state_ff == sfla_pkg::ST_POP)) |-> (head_ff != '0), "pop of an empty list")
   `SFLA_ASSERT(a_error_zero_addr, (rsp_valid_ff && (rsp_status_ff != sfla_pkg::STATUS_OK)) |-> (rsp_addr_ff == '0), "error result with nonzero address")
   `SFLA_ASSERT(a_bump_range, (bump_ff >= sfla_pkg::BUMP_RESET) && (32'(bump_ff) < sfla_pkg::ARENA_BYTES), "bump pointer out of arena")
   `SFLA_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid_ff && req_tready), "not idle after reset")

endmodule

`default_nettype wire

/* rtl/segregated_free_list_allocator.sv */
// Segregated free-list allocator: size-class heads, per-block length/link stores, bump pointer.
//
// Usage:
//  - req channel: req_tuser = op (0 allocate, 1 free); req_tdata carries the
//    requested length and the address of the block to free. One request at a
//    time; req_tready is high only while no request is in flight.
//  - rsp channel: exactly one response per request, in order. rsp_tdata is the
//    allocated address (0 for a free or an error), rsp_tuser the status
//    (0 ok, 1 length too large, 2 arena exhausted).
//  - Steps: an error, a bump allocation or an ignored free is answered from the
//    lookup step; a pop or a push finishes in a further step, after its second
//    synchronous read (link after head, or head after stored length). The next
//    request is taken the cycle after the response loads.
//  - Response stall: the response register holds until taken; the next request
//    may be accepted meanwhile and waits in its final step, with no memory write
//    committed, until the register frees up.
//  - Reset (synchronous, active high): all lists empty (head valid bits cleared),
//    bump pointer back to 516, no response pending. The length and link stores are
//    not cleared; the user must see they are only read for blocks written earlier.
`default_nettype none

module segregated_free_list_allocator #(
   parameter int NUM_CLASSES = sfla_pkg::MAX_CLASSES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [11:0] req_length, [27:12] block_addr, [31:28] zero
   input  wire logic [sfla_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] op
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [15:0] result_addr
   output logic      [sfla_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic      [1:0]                       rsp_tuser
);

   localparam int IDX_W = $clog2(NUM_CLASSES);

   // head table port
   logic                          heads_rd_en;
   logic [IDX_W-1:0]              heads_rd_idx;
   logic                          heads_wr_en;
   logic [IDX_W-1:0]              heads_wr_idx;
   logic [sfla_pkg::ADDR_W-1:0]   heads_wr_data;
   logic [sfla_pkg::ADDR_W-1:0]   heads_rd_data;

   // per-block stores, indexed by header word address
   sfla_pkg::store_cmd_type       len_cmd;
   logic [sfla_pkg::STORED_LEN_W-1:0] len_wr_data;
   logic [sfla_pkg::STORED_LEN_W-1:0] len_rd_data;
   sfla_pkg::store_cmd_type       link_cmd;
   logic [sfla_pkg::ADDR_W-1:0]   link_wr_data;
   logic [sfla_pkg::ADDR_W-1:0]   link_rd_data;

   sfla_ctrl #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .heads_rd_en   (heads_rd_en),
      .heads_rd_idx  (heads_rd_idx),
      .heads_wr_en   (heads_wr_en),
      .heads_wr_idx  (heads_wr_idx),
      .heads_wr_data (heads_wr_data),
      .heads_rd_data (heads_rd_data),
      .len_cmd       (len_cmd),
      .len_wr_data   (len_wr_data),
      .len_rd_data   (len_rd_data),
      .link_cmd      (link_cmd),
      .link_wr_data  (link_wr_data),
      .link_rd_data  (link_rd_data)
   );

   // one head per size class; 0 = empty list
   sfla_heads #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_heads (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (heads_rd_en),
      .rd_idx  (heads_rd_idx),
      .wr_en   (heads_wr_en),
      .wr_idx  (heads_wr_idx),
      .wr_data (heads_wr_data),
      .rd_data (heads_rd_data)
   );

   // stored request length of each allocated block
   sfla_ram #(
      .WIDTH (sfla_pkg::STORED_LEN_W)
   ) u_len_store (
      .clock   (clock),
      .cmd     (len_cmd),
      .wr_data (len_wr_data),
      .rd_data (len_rd_data)
   );

   // next-block link of each free block
   sfla_ram #(
      .WIDTH (sfla_pkg::ADDR_W)
   ) u_link_store (
      .clock   (clock),
      .cmd     (link_cmd),
      .wr_data (link_wr_data),
      .rd_data (link_rd_data)
   );

endmodule

`default_nettype wire

/* verif/segregated_free_list_allocator_test.sv */
// Self-checking testbench for the segregated free-list allocator.
module segregated_free_list_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfla_pkg::*;

   localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
   localparam int HOLD_CYCLES = 300;      // receiver hold-off in the pressure phase
   localparam int TAIL_CYCLES = 8;        // settle margin after the last response
   localparam int PHASE_ITEMS = 160;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } alloc_result_type;

   // One directed request; when has_want is set the response is typed in here,
   // otherwise it comes from the predictor.
   typedef struct packed {
      op_type            op;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] addr;
      logic              has_want;
      logic [ADDR_W-1:0] want_addr;
      status_type        want_status;
   } directed_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [11:0] length, [27:12] block addr, [31:28] zero
   logic                   req_tuser  = 1'b0; // [0] op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [15:0] result addr
   logic [1:0]             rsp_tuser;         // [1:0] status

   segregated_free_list_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Allocator predictor: own copy of the heads, bump pointer and stores.
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]       class_head [MAX_CLASSES];
   logic [BUMP_W-1:0]       bump_addr;
   logic [STORED_LEN_W-1:0] stored_len [STORE_DEPTH];
   logic [ADDR_W-1:0]       next_link  [STORE_DEPTH];

   // Addresses the stimulus may free: only slots whose length was written.
   logic [ADDR_W-1:0] live_blocks [$];
   logic [ADDR_W-1:0] known_blocks [$];

   int n_requests, n_bumps, n_reuses, n_frees, n_too_long, n_exhausted;

   alloc_result_type awaited_responses [$];
   int               accepted_count;
   int               mismatch_count;
   int               cycle_count;

   // Typed-in expectation for the request currently offered.
   logic              want_typed;
   logic [ADDR_W-1:0] typed_addr;
   status_type        typed_status;

   int send_idle_pct;
   int stall_pct;
   int hold_requests;

   function automatic alloc_result_type predict_response(input op_type op,
                                                         input logic [LEN_W-1:0] len,
                                                         input logic [ADDR_W-1:0] addr);
      alloc_result_type r;
      int               cls;
      int               blk;
      int               nxt;
      logic [SLOT_W-1:0] slot;
      r.addr   = '0;
      r.status = STATUS_OK;
      n_requests++;
      if (op == OP_ALLOC) begin
         cls = len / 16;
         if (len >= 12'h400 || cls >= MAX_CLASSES) begin
            r.status = STATUS_TOO_LONG;
            n_too_long++;
         end else begin
            blk = 16 * (cls + 1) + 4;
            if (class_head[cls] != '0) begin
               // reuse: pop the list head, follow its link
               slot            = class_head[cls][ADDR_W-1:2];
               r.addr          = class_head[cls];
               class_head[cls] = next_link[slot];
               stored_len[slot] = len[STORED_LEN_W-1:0];
               n_reuses++;
            end else begin
               nxt = bump_addr + blk;
               if (nxt + blk >= ARENA_BYTES) begin
                  r.status = STATUS_EXHAUSTED;
                  n_exhausted++;
               end else begin
                  r.addr = bump_addr[ADDR_W-1:0];
                  stored_len[bump_addr[ADDR_W-1:2]] = len[STORED_LEN_W-1:0];
                  bump_addr = BUMP_W'(nxt);
                  n_bumps++;
               end
            end
            if (r.status == STATUS_OK) begin
               live_blocks.push_back(r.addr);
               known_blocks.push_back(r.addr);
               if (known_blocks.size() > 256) void'(known_blocks.pop_front());
            end
         end
      end else begin
         slot = addr[ADDR_W-1:2];
         cls  = stored_len[slot] / 16;
         if (cls < MAX_CLASSES) begin
            next_link[slot] = class_head[cls];
            class_head[cls] = addr;
         end
         n_frees++;
         for (int i = live_blocks.size() - 1; i >= 0; i--)
            if (live_blocks[i][ADDR_W-1:2] == slot) live_blocks.delete(i);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH %0s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      mismatch_count++;
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : response_monitor
      alloc_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               report_mismatch("response with no request awaiting one", rsp_tdata, 0);
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_tdata !== want.addr)
                  report_mismatch("result addr", rsp_tdata, want.addr);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_response(op_type'(req_tuser), req_tdata[LEN_W-1:0],
                                    req_tdata[LEN_W+ADDR_W-1:LEN_W]);
            if (want_typed) want = '{addr: typed_addr, status: typed_status};
            awaited_responses.push_back(want);
            accepted_count++;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is asked for.
   int hold_left = 0;
   int hold_seen = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request at a falling edge and return at the falling edge after
   // it is taken, with tvalid still high so back-to-back requests stay gapless.
   task automatic send_request(input op_type op, input logic [LEN_W-1:0] len,
                               input logic [ADDR_W-1:0] addr, input logic has_want,
                               input logic [ADDR_W-1:0] want_addr,
                               input status_type want_status);
      int target;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      want_typed   = has_want;
      typed_addr   = want_addr;
      typed_status = want_status;
      target       = accepted_count + 1;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, addr, len};
      do @(negedge clock); while (accepted_count < target);
   endtask

   // Mostly well-formed alloc/free traffic; some over-length sizes, double
   // frees and unaligned frees. Free addresses always hit a written slot.
   task automatic send_random(input bit big_sizes);
      op_type            op;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] base;
      int                pick;
      op   = OP_ALLOC;
      len  = LEN_W'($urandom_range(4095));
      addr = ADDR_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 40 && known_blocks.size() > 0) begin
         op   = OP_FREE;
         pick = $urandom_range(99);
         if (live_blocks.size() > 0 && pick < 88) begin
            base = live_blocks[$urandom_range(live_blocks.size() - 1)];
            addr = (pick < 76) ? base : {base[ADDR_W-1:2], 2'($urandom_range(3))};
         end else begin
            addr = known_blocks[$urandom_range(known_blocks.size() - 1)];
         end
      end else if (big_sizes) begin
         if (pick < 90) len = LEN_W'($urandom_range(1023, 512));
      end else begin
         if (pick < 85) len = LEN_W'($urandom_range(63));
         else if (pick < 95) len = LEN_W'($urandom_range(1023, 64));
      end
      send_request(op, len, addr, 1'b0, '0, STATUS_OK);
   endtask

   // Idle mixes change on a rising edge so the receiver never races them.
   task automatic set_idling(input int send_pct, input int recv_pct);
      req_tvalid <= 1'b0;
      @(posedge clock);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(negedge clock);
   endtask

   // Directed requests, walked in order from reset. Addresses follow from the
   // bump pointer starting at 516 and 16*(class+1)+4 bytes per block.
   directed_row_type directed_rows [21] = '{
      // first blocks off the bump pointer; addr field of an allocate is ignored
      '{OP_ALLOC, 12'd0,    16'hFFFF, 1'b1, 16'd516, STATUS_OK},
      '{OP_ALLOC, 12'd15,   16'h0000, 1'b1, 16'd536, STATUS_OK},
      '{OP_ALLOC, 12'd16,   16'h5555, 1'b1, 16'd556, STATUS_OK},
      '{OP_ALLOC, 12'd1023, 16'hAAAA, 1'b1, 16'd592, STATUS_OK},
      // over-length sizes
      '{OP_ALLOC, 12'd1024, 16'h0000, 1'b1, 16'd0,   STATUS_TOO_LONG},
      '{OP_ALLOC, 12'd4095, 16'h0000, 1'b1, 16'd0,   STATUS_TOO_LONG},
      '{OP_ALLOC, 12'd2048, 16'h0000, 1'b1, 16'd0,   STATUS_TOO_LONG},
      '{OP_ALLOC, 12'd1039, 16'h0000, 1'b1, 16'd0,   STATUS_TOO_LONG},
      // free then reuse from the class-0 list
      '{OP_FREE,  12'd4095, 16'd516,  1'b1, 16'd0,   STATUS_OK},
      '{OP_ALLOC, 12'd7,    16'h0000, 1'b1, 16'd516, STATUS_OK},
      // unaligned free is pushed as given and handed back as given
      '{OP_FREE,  12'd0,    16'd536,  1'b1, 16'd0,   STATUS_OK},
      '{OP_FREE,  12'd0,    16'd517,  1'b1, 16'd0,   STATUS_OK},
      '{OP_ALLOC, 12'd1,    16'h0000, 1'b1, 16'd517, STATUS_OK},
      '{OP_ALLOC, 12'd2,    16'h0000, 1'b1, 16'd536, STATUS_OK},
      // repeated free of the same block links it to itself
      '{OP_FREE,  12'd0,    16'd592,  1'b1, 16'd0,   STATUS_OK},
      '{OP_FREE,  12'd0,    16'd592,  1'b1, 16'd0,   STATUS_OK},
      '{OP_ALLOC, 12'd1008, 16'h0000, 1'b1, 16'd592, STATUS_OK},
      '{OP_ALLOC, 12'd1015, 16'h0000, 1'b1, 16'd592, STATUS_OK},
      // left to the predictor
      '{OP_FREE,  12'd0,    16'd556,  1'b0, 16'd0,   STATUS_OK},
      '{OP_ALLOC, 12'd31,   16'h0000, 1'b0, 16'd0,   STATUS_OK},
      '{OP_ALLOC, 12'd32,   16'h0000, 1'b0, 16'd0,   STATUS_OK}
   };

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int n;
      for (int i = 0; i < MAX_CLASSES; i++) class_head[i] = '0;
      bump_addr      = BUMP_RESET;
      accepted_count = 0;
      mismatch_count = 0;
      want_typed     = 1'b0;
      typed_addr     = '0;
      typed_status   = STATUS_OK;
      send_idle_pct  = 0;
      stall_pct      = 0;
      hold_requests  = 0;
      n_requests = 0; n_bumps = 0; n_reuses = 0;
      n_frees = 0; n_too_long = 0; n_exhausted = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].length, directed_rows[i].addr,
                      directed_rows[i].has_want, directed_rows[i].want_addr,
                      directed_rows[i].want_status);

      // random traffic under each idle mix, small sizes so the arena lasts
      set_idling(0, 0);
      repeat (PHASE_ITEMS) send_random(1'b0);
      set_idling(61, 0);
      repeat (PHASE_ITEMS) send_random(1'b0);
      set_idling(0, 61);
      repeat (PHASE_ITEMS) send_random(1'b0);
      set_idling(8, 8);
      repeat (PHASE_ITEMS) send_random(1'b0);

      // pressure: receiver holds off while requests keep coming, then the
      // sender stops until everything outstanding has come back
      set_idling(0, 0);
      req_tvalid <= 1'b0;
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      repeat (30) send_random(1'b0);
      wait_for_responses();

      // large sizes fill the arena, then keep going on reuse and frees
      set_idling(8, 8);
      n = 0;
      while ((n_exhausted < 20 || n < 120) && n < 600) begin
         send_random(1'b1);
         n++;
      end

      wait_for_responses();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_responses.size() != 0)
         report_mismatch("responses never delivered", awaited_responses.size(), 0);

      $display("Covered %0d requests: %0d bump allocs, %0d list reuses, %0d frees,",
               n_requests, n_bumps, n_reuses, n_frees);
      $display("  %0d over-length, %0d arena-full; idle mixes and a %0d-cycle hold-off",
               n_too_long, n_exhausted, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

/* segregated_free_list_allocator.f */
+incdir+rtl
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_heads.sv
rtl/sfla_ctrl.sv
rtl/segregated_free_list_allocator.sv
verif/segregated_free_list_allocator_test.sv
